// ----- sv/ens_pkg.sv -----
// Package for the e series core: sizes, operation codes and controller states.
package ens_pkg;

   localparam int LIMBS       = 512;
   localparam int LIMB_BASE   = 100;
   localparam int LIMB_W      = 7;
   localparam int IDX_W       = $clog2(LIMBS);
   localparam int INDEX_W     = 9;
   localparam int DIV_W       = 16;
   localparam int ACC_W       = DIV_W + LIMB_W;
   localparam int BIT_W       = $clog2(LIMB_W);
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;

   localparam logic [DIV_W-1:0] DIVISOR_MAX = {DIV_W{1'b1}};

   typedef enum logic [REQ_TUSER_W-1:0] {
      OP_RESTART = 2'd0,
      OP_STEP    = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_DIV_RD,
      ST_DIV_LOAD,
      ST_DIV_ITER,
      ST_DONE
   } state_type;

endpackage

// ----- sv/euler_number_series_limbs_core.sv -----
// Top level of the e series core: sum of inverse factorials over base-100 limbs.
//
//   channel | dir | ports                      | contents
//   req     | in  | req_tvalid/tready/tdata/tuser | tuser: operation, tdata: limb_index
//   rsp     | out | rsp_tvalid/tready/tdata    | limb_value, term_count, term_zero
//
// A read goes straight to the response; a restart runs a clearing pass, and a step runs a
// carry add over every limb, then a bit-serial long division over every limb
// (one quotient bit per cycle), all through one-port sum and term memories.
// After convergence a step skips the add and the division and only responds.
// Reset runs a clearing pass through both memories; no request
// is taken until it ends. A request is taken while an earlier response still waits.
module euler_number_series_limbs_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ens_pkg::REQ_TDATA_W-1:0] req_tdata,  // [8:0] limb_index, rest zero
   input  logic [ens_pkg::REQ_TUSER_W-1:0] req_tuser,  // [1:0] operation
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ens_pkg::RSP_TDATA_W-1:0] rsp_tdata   // [6:0] limb_value,
                                                      // [22:7] term_count, [23] term_zero
);
   import ens_pkg::*;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               carry_ff, carry_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [LIMB_W-1:0]  quo_ff, quo_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic               nz_ff, nz_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic               tz_ff, tz_in;
   logic               pend_ff, pend_in;
   logic               rng_ff, rng_in;
   logic [LIMB_W-1:0]  limb_ff, limb_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [LIMB_W-1:0]  sum_mem_ff [LIMBS];
   logic [LIMB_W-1:0]  term_mem_ff [LIMBS];
   logic [LIMB_W-1:0]  sum_rd_ff, term_rd_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               sum_we, term_we;
   logic [LIMB_W-1:0]  sum_wd, term_wd;

   logic [LIMB_W:0]    add_sum;
   logic [ACC_W-1:0]   div_shift;
   logic               div_ge;
   logic [ACC_W-1:0]   acc_nx;
   logic [LIMB_W-1:0]  quo_nx;
   logic               quo_nz;
   logic [INDEX_W-1:0] req_index;
   op_type             req_op;

   assign req_index  = req_tdata[INDEX_W-1:0];
   assign req_op     = op_type'(req_tuser);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign rd_addr    = (state_ff == ST_IDLE) ? IDX_W'(req_index) : idx_ff;

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem_ff[idx_ff] <= sum_wd;
      end
      if (term_we) begin
         term_mem_ff[idx_ff] <= term_wd;
      end
      sum_rd_ff  <= sum_mem_ff[rd_addr];
      term_rd_ff <= term_mem_ff[rd_addr];
   end

   assign add_sum   = {1'b0, sum_rd_ff} + {1'b0, term_rd_ff} + (LIMB_W+1)'(carry_ff);
   assign div_shift = ACC_W'(div_ff) << bit_ff;
   assign div_ge    = (acc_ff >= div_shift);
   assign acc_nx    = div_ge ? (acc_ff - div_shift) : acc_ff;
   assign quo_nx    = div_ge ? (quo_ff | (LIMB_W'(1) << bit_ff)) : quo_ff;
   assign quo_nz    = (quo_nx != '0);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      carry_in     = carry_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      nz_in        = nz_ff;
      div_in       = div_ff;
      tz_in        = tz_ff;
      pend_in      = pend_ff;
      rng_in       = rng_ff;
      limb_in      = limb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      sum_we       = 1'b0;
      term_we      = 1'b0;
      sum_wd       = '0;
      term_wd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            sum_we  = 1'b1;
            term_we = 1'b1;
            term_wd = (idx_ff == '0) ? LIMB_W'(1) : '0;
            if (idx_ff == IDX_W'(LIMBS - 1)) begin
               idx_in   = '0;
               state_in = pend_ff ? ST_DONE : ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               pend_in = 1'b1;
               limb_in = '0;
               case (req_op)
                  OP_RESTART: begin
                     div_in   = DIV_W'(1);
                     tz_in    = 1'b0;
                     idx_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  OP_STEP: begin
                     if (tz_ff) begin
                        state_in = ST_DONE;
                     end else begin
                        idx_in   = IDX_W'(LIMBS - 1);
                        carry_in = 1'b0;
                        state_in = ST_ADD_RD;
                     end
                  end
                  OP_READ: begin
                     rng_in   = ({1'b0, req_index} < (INDEX_W+1)'(LIMBS));
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            limb_in  = rng_ff ? sum_rd_ff : '0;
            state_in = ST_DONE;
         end
         ST_ADD_RD: begin
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            sum_we = 1'b1;
            if (add_sum >= (LIMB_W+1)'(LIMB_BASE)) begin
               sum_wd   = LIMB_W'(add_sum - (LIMB_W+1)'(LIMB_BASE));
               carry_in = 1'b1;
            end else begin
               sum_wd   = LIMB_W'(add_sum);
               carry_in = 1'b0;
            end
            if (idx_ff == '0) begin
               rem_in   = '0;
               nz_in    = 1'b0;
               state_in = ST_DIV_RD;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = ST_ADD_RD;
            end
         end
         ST_DIV_RD: begin
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            acc_in   = ACC_W'(rem_ff) * ACC_W'(LIMB_BASE) + ACC_W'(term_rd_ff);
            quo_in   = '0;
            bit_in   = BIT_W'(LIMB_W - 1);
            state_in = ST_DIV_ITER;
         end
         ST_DIV_ITER: begin
            acc_in = acc_nx;
            quo_in = quo_nx;
            if (bit_ff == '0) begin
               term_we = 1'b1;
               term_wd = quo_nx;
               nz_in   = nz_ff || quo_nz;
               rem_in  = DIV_W'(acc_nx);
               if (idx_ff == IDX_W'(LIMBS - 1)) begin
                  div_in   = (div_ff < DIVISOR_MAX) ? div_ff + DIV_W'(1) : div_ff;
                  tz_in    = !(nz_ff || quo_nz);
                  idx_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_DIV_RD;
               end
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {tz_ff, div_ff, limb_ff};
               pend_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         div_ff       <= DIV_W'(1);
         tz_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         div_ff       <= div_in;
         tz_ff        <= tz_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff    <= carry_in;
      rem_ff      <= rem_in;
      acc_ff      <= acc_in;
      quo_ff      <= quo_in;
      bit_ff      <= bit_in;
      nz_ff       <= nz_in;
      rng_ff      <= rng_in;
      limb_ff     <= limb_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_ff != '0)
      else $error("divisor reached zero");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_LOAD) |-> (rem_ff < div_ff))
      else $error("division remainder not below divisor");

   a_quo_in_base: assert property (@(posedge clock) disable iff (reset)
      term_we && (state_ff == ST_DIV_ITER) |-> (term_wd < LIMB_W'(LIMB_BASE)))
      else $error("term limb out of base");

   a_sum_in_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD_WR) |-> (sum_wd < LIMB_W'(LIMB_BASE)))
      else $error("sum limb out of base");

   a_converged_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_STEP) && tz_ff |=> $stable(div_ff))
      else $error("converged step changed the divisor");

endmodule

// ----- sim/euler_number_series_limbs_core_test.sv -----
// Testbench for the e series core: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module euler_number_series_limbs_core_test;
   import ens_pkg::*;

   localparam logic [REQ_TUSER_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [LIMB_W-1:0] limb;
      logic [DIV_W-1:0]  count;
      logic              zero;
   } readout_type;

   typedef struct packed {
      logic [REQ_TUSER_W-1:0] op;
      logic [INDEX_W-1:0]     idx;
      logic                   fixed;
      readout_type            value;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic [LIMB_W-1:0] sum_digits [LIMBS];
   logic [LIMB_W-1:0] term_digits [LIMBS];
   logic [DIV_W-1:0]  next_divisor;
   logic              term_cleared;

   readout_type  pending_readouts [$];
   stim_row_type directed_rows [$];
   int           mismatch_count = 0;
   bit           steady = 1'b0;

   euler_number_series_limbs_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic readout_type advance_series(input logic [REQ_TUSER_W-1:0] op,
                                                  input logic [INDEX_W-1:0] idx);
      readout_type r;
      int unsigned carry;
      int unsigned total;
      int unsigned rem;
      int unsigned acc;
      bit          all_zero;
      r = '0;
      case (op)
         OP_RESTART: begin
            for (int i = 0; i < LIMBS; i++) begin
               sum_digits[i] = '0;
               term_digits[i] = '0;
            end
            term_digits[0] = LIMB_W'(1);
            next_divisor = DIV_W'(1);
            term_cleared = 1'b0;
         end
         OP_STEP: begin
            if (!term_cleared) begin
               carry = 0;
               for (int i = LIMBS - 1; i >= 0; i--) begin
                  total = sum_digits[i] + term_digits[i] + carry;
                  carry = total / LIMB_BASE;
                  sum_digits[i] = LIMB_W'(total % LIMB_BASE);
               end
               rem = 0;
               all_zero = 1'b1;
               for (int i = 0; i < LIMBS; i++) begin
                  acc = rem * LIMB_BASE + term_digits[i];
                  term_digits[i] = LIMB_W'(acc / next_divisor);
                  rem = acc % next_divisor;
                  if (term_digits[i] != 0) all_zero = 1'b0;
               end
               if (next_divisor != DIVISOR_MAX) next_divisor = next_divisor + 1'b1;
               term_cleared = all_zero;
            end
         end
         OP_READ: begin
            if (idx < LIMBS) r.limb = sum_digits[idx];
         end
         default: begin
         end
      endcase
      r.count = next_divisor;
      r.zero = term_cleared;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_request(input logic [REQ_TUSER_W-1:0] op, input logic [INDEX_W-1:0] idx,
                               input bit fixed, input readout_type fixed_value);
      readout_type predicted;
      if (!steady && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {{(REQ_TDATA_W - INDEX_W){1'b0}}, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_series(op, idx);
      pending_readouts.push_back(fixed ? fixed_value : predicted);
      @(negedge clock);
   endtask

   task automatic send_random(input logic [REQ_TUSER_W-1:0] op);
      logic [INDEX_W-1:0] idx;
      idx = ($urandom_range(1) == 0) ? INDEX_W'($urandom_range(3)) : INDEX_W'($urandom_range(511));
      send_request(op, idx, 1'b0, '0);
   endtask

   task automatic send_reads;
      repeat ($urandom_range(1, 3)) send_random(OP_READ);
      if ($urandom_range(9) == 0) send_random(REQ_TUSER_W'($urandom_range(3)));
   endtask

   task automatic wait_for_readouts;
      req_tvalid <= 1'b0;
      while (pending_readouts.size() != 0) @(negedge clock);
   endtask

   function automatic void add_row(input logic [REQ_TUSER_W-1:0] op,
                                   input logic [INDEX_W-1:0] idx, input int fixed,
                                   input int limb, input int count, input int zero);
      stim_row_type row;
      row.op = op;
      row.idx = idx;
      row.fixed = (fixed != 0);
      row.value.limb = LIMB_W'(limb);
      row.value.count = DIV_W'(count);
      row.value.zero = (zero != 0);
      directed_rows.push_back(row);
   endfunction

   always @(negedge clock) begin
      rsp_tready <= !reset && (steady || $urandom_range(99) >= 20);
   end

   always @(posedge clock) begin : check_readout
      readout_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readouts.size() == 0) begin
            report_mismatch("unexpected response", int'(rsp_tdata), 0);
         end else begin
            want = pending_readouts.pop_front();
            if (rsp_tdata[6:0] != want.limb)
               report_mismatch("limb_value", int'(rsp_tdata[6:0]), int'(want.limb));
            if (rsp_tdata[22:7] != want.count)
               report_mismatch("term_count", int'(rsp_tdata[22:7]), int'(want.count));
            if (rsp_tdata[23] != want.zero)
               report_mismatch("term_zero", int'(rsp_tdata[23]), int'(want.zero));
         end
      end
   end

   initial begin
      #(64'd300_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      void'(advance_series(OP_RESTART, '0));

      // after reset, extremes of the index, unused code, first few terms by hand
      add_row(OP_READ,    9'd0,   1, 0,  1, 0);
      add_row(OP_READ,    9'h1FF, 1, 0,  1, 0);
      add_row(OP_UNUSED,  9'h1FF, 1, 0,  1, 0);
      add_row(OP_STEP,    9'd0,   1, 0,  2, 0);
      add_row(OP_READ,    9'd0,   1, 1,  2, 0);
      add_row(OP_STEP,    9'd0,   1, 0,  3, 0);
      add_row(OP_READ,    9'd0,   1, 2,  3, 0);
      add_row(OP_READ,    9'd1,   1, 0,  3, 0);
      add_row(OP_STEP,    9'd0,   1, 0,  4, 0);
      add_row(OP_READ,    9'd1,   1, 50, 4, 0);
      add_row(OP_STEP,    9'd0,   0, 0,  0, 0);
      add_row(OP_READ,    9'd1,   0, 0,  0, 0);
      add_row(OP_READ,    9'd2,   0, 0,  0, 0);
      add_row(OP_READ,    9'h1FF, 0, 0,  0, 0);
      add_row(OP_READ,    9'h155, 0, 0,  0, 0);
      add_row(OP_READ,    9'h0AA, 0, 0,  0, 0);
      add_row(OP_UNUSED,  9'd0,   0, 0,  0, 0);
      add_row(OP_STEP,    9'h1FF, 0, 0,  0, 0);
      add_row(OP_RESTART, 9'h1FF, 1, 0,  1, 0);
      add_row(OP_READ,    9'd0,   1, 0,  1, 0);
      add_row(OP_READ,    9'd1,   1, 0,  1, 0);
      add_row(OP_STEP,    9'd0,   1, 0,  2, 0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].idx,
                      directed_rows[i].fixed, directed_rows[i].value);

      // short series with random reads in between
      for (int phase = 0; phase < 12; phase++) begin
         steady = (phase >= 4 && phase < 8);
         send_random(OP_RESTART);
         send_reads();
         repeat ($urandom_range(5)) begin
            send_random(OP_STEP);
            send_reads();
         end
      end
      steady = 1'b0;

      // hold until idle, then run one series all the way to convergence
      wait_for_readouts();
      send_random(OP_RESTART);
      while (!term_cleared) begin
         send_random(OP_STEP);
         if ($urandom_range(19) == 0) send_random(OP_READ);
      end
      repeat (4) begin
         send_random(OP_STEP);
         send_reads();
      end
      for (int i = 0; i < 4; i++) send_request(OP_READ, INDEX_W'(i), 1'b0, '0);
      send_random(OP_UNUSED);
      send_random(OP_RESTART);
      send_random(OP_STEP);
      send_reads();

      req_tvalid <= 1'b0;
      wait_for_readouts();
      repeat (16) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
